[rtl/set_assoc_lru_cache_sim_top_macros.svh]
// Assertion macros shared by the cache simulator RTL.
`ifndef SET_ASSOC_LRU_CACHE_SIM_TOP_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SALC_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SALC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/salc_pkg.sv]
// Shared types, codes and helpers for the set-associative LRU cache simulator.
package salc_pkg;

   localparam int ADDR_W  = 64;
   localparam int TAG_W   = 32;
   localparam int COUNT_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;

   // Access kinds
   localparam logic KIND_ACCESS = 1'b0;
   localparam logic KIND_MODIFY = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_INDEX_BITS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS_IN_USE       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_OFFSET_BITS = 2'd2;

   // Configuration reset values
   localparam logic [3:0] RESET_SET_INDEX_BITS    = 4'd4;
   localparam logic [3:0] RESET_WAYS_IN_USE       = 4'd1;
   localparam logic [5:0] RESET_BLOCK_OFFSET_BITS = 6'd4;

   typedef enum logic [1:0] {
      OUTCOME_HIT   = 2'd0,
      OUTCOME_MISS  = 2'd1,
      OUTCOME_EVICT = 2'd2
   } outcome_type;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]         outcome;
      logic [COUNT_W-1:0] hit_count;
      logic [COUNT_W-1:0] miss_count;
      logic [COUNT_W-1:0] eviction_count;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic clear;
      logic accept;
      logic look;
      logic pick;
      logic commit;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } ctrl_sts_type;

   // Add a small amount to a count, sticking at all ones.
   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] count,
                                                  input logic [1:0] amount);
      logic [COUNT_W:0] sum;
      sum = {1'b0, count} + (COUNT_W + 1)'(amount);
      return sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
   endfunction

endpackage

[rtl/salc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                clock,
   input  logic                we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]    wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]    rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/salc_ctrl.sv]
// Sequencing controller: clearing pass, then accept, lookup, victim pick and update.
module salc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  salc_pkg::ctrl_sts_type  sts,
   output salc_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_PICK,
      ST_UPDATE
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold until the result register can take the beat
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

[rtl/salc_dpath.sv]
// Datapath: configuration, address split, set store, LRU victim tree and counters.
module salc_dpath #(
   parameter int MAX_SET_BITS = 8,
   parameter int MAX_WAYS     = 8,
   parameter int STAMP_WIDTH  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  salc_pkg::ctrl_cmd_type               cmd,
   output salc_pkg::ctrl_sts_type               sts,
   input  salc_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output salc_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [salc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [salc_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int SET_DEPTH = 2 ** MAX_SET_BITS;
   localparam int SET_AW    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int WIW       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCW       = $clog2(MAX_WAYS + 1);
   localparam int TREE_N    = 2 ** WIW;
   localparam int TAG_W     = salc_pkg::TAG_W;
   localparam int LINE_W    = 1 + TAG_W + STAMP_WIDTH;
   localparam int ROW_W     = MAX_WAYS * LINE_W;
   localparam int COUNT_W   = salc_pkg::COUNT_W;

   // Configuration registers
   logic [3:0] set_bits_ff;
   logic [3:0] ways_ff;
   logic [5:0] boff_ff;

   // Effective configuration
   logic [3:0]          sbits_eff;
   logic [WCW-1:0]      ways_eff;
   logic [TREE_N-1:0]   way_en;

   // Address split
   logic [6:0]                  tshift;
   logic [salc_pkg::ADDR_W-1:0] addr_off;
   logic [salc_pkg::ADDR_W-1:0] addr_tag;
   logic [TAG_W-1:0]            req_tag;
   logic [SET_AW-1:0]           set_mask;
   logic [SET_AW-1:0]           req_set;

   // Per-item registers
   logic [TAG_W-1:0]       tag_ff;
   logic [SET_AW-1:0]      set_ff;
   logic                   modify_ff;
   logic [STAMP_WIDTH-1:0] clock_ff;
   logic [STAMP_WIDTH-1:0] clock_in;

   // Lookup stage
   logic [ROW_W-1:0]       ram_rdata;
   logic [ROW_W-1:0]       row_ff;
   logic [STAMP_WIDTH-1:0] clk_next;
   logic [MAX_WAYS-1:0]    match_in;
   logic [MAX_WAYS-1:0]    match_ff;
   logic [MAX_WAYS-1:0]    inval_in;
   logic [MAX_WAYS-1:0]    inval_ff;
   logic [STAMP_WIDTH-1:0] age_in [TREE_N];
   logic [STAMP_WIDTH-1:0] age_ff [TREE_N];

   // Pick stage
   logic [STAMP_WIDTH-1:0] node_age [2*TREE_N-1];
   logic [WIW-1:0]         node_idx [2*TREE_N-1];
   logic [WIW-1:0]         hit_way;
   logic [WIW-1:0]         fill_way;
   logic [WIW-1:0]         way_in;
   logic [WIW-1:0]         way_ff;
   salc_pkg::outcome_type  outcome_in;
   salc_pkg::outcome_type  outcome_ff;

   // Update stage
   logic [STAMP_WIDTH-1:0] stamp_step;
   logic [STAMP_WIDTH-1:0] stamp_new;
   logic [ROW_W-1:0]       row_new;
   logic [1:0]             hit_add;
   logic [1:0]             miss_add;
   logic [1:0]             evict_add;
   logic [COUNT_W-1:0]     hits_ff;
   logic [COUNT_W-1:0]     hits_in;
   logic [COUNT_W-1:0]     misses_ff;
   logic [COUNT_W-1:0]     misses_in;
   logic [COUNT_W-1:0]     evicts_ff;
   logic [COUNT_W-1:0]     evicts_in;
   logic                   rsp_valid_ff;
   salc_pkg::rsp_type      rsp_data_ff;

   // Clearing pass and RAM ports
   logic [SET_AW-1:0] clr_cnt_ff;
   logic              ram_we;
   logic [SET_AW-1:0] ram_waddr;
   logic [ROW_W-1:0]  ram_wdata;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff <= salc_pkg::RESET_SET_INDEX_BITS;
         ways_ff     <= salc_pkg::RESET_WAYS_IN_USE;
         boff_ff     <= salc_pkg::RESET_BLOCK_OFFSET_BITS;
      end else if (csr_we) begin
         unique case (csr_index)
            salc_pkg::CSR_SET_INDEX_BITS:    set_bits_ff <= csr_data[3:0];
            salc_pkg::CSR_WAYS_IN_USE:       ways_ff     <= csr_data[3:0];
            salc_pkg::CSR_BLOCK_OFFSET_BITS: boff_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Clamp set bits and ways into range
   assign sbits_eff = (set_bits_ff > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits_ff;

   always_comb begin
      if (ways_ff == 4'd0) begin
         ways_eff = WCW'(1);
      end else if ({1'b0, ways_ff} > 5'(MAX_WAYS)) begin
         ways_eff = WCW'(MAX_WAYS);
      end else begin
         ways_eff = WCW'(ways_ff);
      end
      for (int w = 0; w < TREE_N; w++) begin
         way_en[w] = (w < int'(ways_eff));
      end
   end

   // Split the address into set and tag
   assign tshift   = {1'b0, boff_ff} + {3'b000, sbits_eff};
   assign addr_off = req_data.address >> boff_ff;
   assign addr_tag = req_data.address >> tshift;
   assign req_tag  = tshift[6] ? '0 : addr_tag[TAG_W-1:0];

   always_comb begin
      for (int i = 0; i < SET_AW; i++) begin
         set_mask[i] = (i < int'(sbits_eff));
      end
   end

   assign req_set = addr_off[SET_AW-1:0] & set_mask;

   // Capture the accepted beat
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         tag_ff    <= req_tag;
         set_ff    <= req_set;
         modify_ff <= (req_data.kind == salc_pkg::KIND_MODIFY);
      end
   end

   // Set store: one row holds every way of a set
   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SET_DEPTH)
   ) u_set_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (req_set),
      .rdata (ram_rdata)
   );

   // Compare tags and age every way of the row
   assign clk_next = clock_ff + STAMP_WIDTH'(1);

   always_comb begin
      logic                   line_valid;
      logic [TAG_W-1:0]       line_tag;
      logic [STAMP_WIDTH-1:0] line_stamp;
      for (int k = 0; k < TREE_N; k++) begin
         age_in[k] = '0;
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         line_valid  = ram_rdata[w*LINE_W + LINE_W - 1];
         line_tag    = ram_rdata[w*LINE_W + STAMP_WIDTH +: TAG_W];
         line_stamp  = ram_rdata[w*LINE_W +: STAMP_WIDTH];
         match_in[w] = way_en[w] && line_valid && (line_tag == tag_ff);
         inval_in[w] = way_en[w] && !line_valid;
         age_in[w]   = way_en[w] ? (clk_next - line_stamp) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.look) begin
         row_ff   <= ram_rdata;
         match_ff <= match_in;
         inval_ff <= inval_in;
         for (int k = 0; k < TREE_N; k++) begin
            age_ff[k] <= age_in[k];
         end
      end
   end

   // Oldest-way tree; the lower way wins a tie
   always_comb begin
      for (int k = 0; k < TREE_N; k++) begin
         node_age[TREE_N-1+k] = age_ff[k];
         node_idx[TREE_N-1+k] = WIW'(k);
      end
      for (int i = TREE_N - 2; i >= 0; i--) begin
         if (node_age[2*i+2] > node_age[2*i+1]) begin
            node_age[i] = node_age[2*i+2];
            node_idx[i] = node_idx[2*i+2];
         end else begin
            node_age[i] = node_age[2*i+1];
            node_idx[i] = node_idx[2*i+1];
         end
      end
   end

   // Lowest matching way and lowest free way
   always_comb begin
      hit_way  = '0;
      fill_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (match_ff[w]) begin
            hit_way = WIW'(w);
         end
         if (inval_ff[w]) begin
            fill_way = WIW'(w);
         end
      end
      if (|match_ff) begin
         way_in     = hit_way;
         outcome_in = salc_pkg::OUTCOME_HIT;
      end else if (|inval_ff) begin
         way_in     = fill_way;
         outcome_in = salc_pkg::OUTCOME_MISS;
      end else begin
         way_in     = node_idx[0];
         outcome_in = salc_pkg::OUTCOME_EVICT;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         way_ff     <= way_in;
         outcome_ff <= outcome_in;
      end
   end

   // Refresh the chosen line; a modify adds a second hit on it
   assign stamp_step = modify_ff ? STAMP_WIDTH'(2) : STAMP_WIDTH'(1);
   assign stamp_new  = clock_ff + stamp_step;
   assign clock_in   = stamp_new;

   always_comb begin
      row_new = row_ff;
      row_new[way_ff*LINE_W +: LINE_W] = {1'b1, tag_ff, stamp_new};
   end

   assign hit_add   = 2'(outcome_ff == salc_pkg::OUTCOME_HIT) + 2'(modify_ff);
   assign miss_add  = 2'(outcome_ff != salc_pkg::OUTCOME_HIT);
   assign evict_add = 2'(outcome_ff == salc_pkg::OUTCOME_EVICT);
   assign hits_in   = salc_pkg::sat_add(hits_ff, hit_add);
   assign misses_in = salc_pkg::sat_add(misses_ff, miss_add);
   assign evicts_in = salc_pkg::sat_add(evicts_ff, evict_add);

   // Running state
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff  <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
      end else if (cmd.commit) begin
         clock_ff  <= clock_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         evicts_ff <= evicts_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff.outcome        <= outcome_ff;
         rsp_data_ff.hit_count      <= hits_in;
         rsp_data_ff.miss_count     <= misses_in;
         rsp_data_ff.eviction_count <= evicts_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Advance the clearing pass one row a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_ff + SET_AW'(1);
      end
   end

   assign ram_we    = cmd.clear || cmd.commit;
   assign ram_waddr = cmd.clear ? clr_cnt_ff : set_ff;
   assign ram_wdata = cmd.clear ? '0 : row_new;

   assign sts.clear_last = (clr_cnt_ff == SET_AW'(SET_DEPTH - 1));
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

[rtl/set_assoc_lru_cache_sim_top.sv]
// Top level of the set-associative LRU cache tag-store simulator.
// Each accepted access goes through four steps (accept and set read, tag compare
// and aging, oldest-way selection, write-back); the controller walks one item at
// a time through those steps around the set RAM, which holds all ways of a set in
// one row behind a registered read, and takes no new item before the last one is
// written back. A finished result sits in an output register, and the write-back
// of the next item waits there only while that result is still stalled. After
// reset a clearing pass writes every row of the set RAM, 2^MAX_SET_BITS rows (256
// by default), with req_stall high; configuration writes are taken at any time
// and always see csr_ready.
`include "set_assoc_lru_cache_sim_top_macros.svh"

module set_assoc_lru_cache_sim_top #(
   parameter int MAX_SET_BITS = 8,
   parameter int MAX_WAYS     = 8,
   parameter int STAMP_WIDTH  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  salc_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output salc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [salc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [salc_pkg::CSR_DATA_W-1:0]   csr_data
);

   salc_pkg::ctrl_cmd_type cmd;
   salc_pkg::ctrl_sts_type sts;

   assign csr_ready = 1'b1;

   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   salc_dpath #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .STAMP_WIDTH  (STAMP_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Busy right after a beat is taken
   `SALC_ASSERT_RUN(a_busy_after_accept, req_valid && !req_stall |=> req_stall, "accepted beat did not start work")
   // A result only appears out of a busy cycle
   `SALC_ASSERT_RUN(a_result_from_work, $rose(rsp_valid) |-> $past(req_stall), "result appeared without an item in work")
   // No beat is taken while the clearing pass starts
   `SALC_ASSERT_ALWAYS(a_clear_after_reset, $fell(reset) |-> req_stall, "input open before the set store was cleared")

endmodule
